FILE: hw/rtl/vslt_pkg.sv
// Shared constants and types for the versioned slot lease table.
package vslt_pkg;

   localparam int SLOTS = 16;
   localparam int SLOT_W = 4;
   localparam int CNT_W = 5;

   localparam logic [2:0] OP_PREPARE = 3'd0;
   localparam logic [2:0] OP_PUBLISH = 3'd1;
   localparam logic [2:0] OP_ACQ_ACTIVE = 3'd2;
   localparam logic [2:0] OP_ACQ_GEN = 3'd3;
   localparam logic [2:0] OP_RESOLVE = 3'd4;
   localparam logic [2:0] OP_RELEASE = 3'd5;
   localparam logic [2:0] OP_COLLECT = 3'd6;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_INVALID = 3'd1;
   localparam logic [2:0] ST_CAPACITY = 3'd2;
   localparam logic [2:0] ST_OVERFLOW = 3'd3;
   localparam logic [2:0] ST_NOT_PREPARED = 3'd4;
   localparam logic [2:0] ST_STALE = 3'd5;
   localparam logic [2:0] ST_BAD_STATE = 3'd6;

   localparam logic [1:0] S_FREE = 2'd0;
   localparam logic [1:0] S_PREPARED = 2'd1;
   localparam logic [1:0] S_ACTIVE = 2'd2;
   localparam logic [1:0] S_RETIRED = 2'd3;

   typedef logic [SLOT_W-1:0] slot_type;

endpackage

FILE: hw/rtl/versioned_slot_lease_table.sv
// Versioned slot lease table: top level with sequencer and slot store.
//
// Usage: raise start with one request beat on the req_ ports while busy is
// low; the beat is taken at that edge and busy rises. The block then runs a
// small sequencer that reads one slot per cycle through a single shared
// compare unit. Prepare, acquire by generation and collect scan the slots in
// use, one slot per cycle, then finish; the other operations read once and
// then finish. Prepare and acquire by generation stop at the first match.
// Exactly one result beat follows each request: rsp_valid is high for one
// cycle with the rsp_ fields, and the receiver cannot hold it off. busy
// drops in that cycle, so the next request can be taken at the edge ending it.
// The csr_ channel writes slots_in_use (1..16, larger acts as 16, zero means
// no slot); csr_ready is high only while the block is idle. Reset clears all
// slots to free and zero, the generation counter and the active pointer, and
// sets slots_in_use to 16. Slot storage is flip-flops cleared at reset.
module versioned_slot_lease_table
   import vslt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [3:0]  req_slot,
   input  logic        req_handle_has_record,
   input  logic [63:0] req_handle_generation,
   input  logic        req_handle_leased,
   input  logic        req_patch_ok,
   input  logic [63:0] req_module_hash,
   input  logic [63:0] req_content_hash,
   input  logic [63:0] req_contract_hash,
   input  logic [31:0] req_target_profile,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_slot_out,
   output logic [63:0] rsp_result_generation,
   output logic [63:0] rsp_expected_generation,
   output logic [31:0] rsp_count_out,
   output logic        rsp_leased_out,
   output logic [1:0]  rsp_record_state,
   output logic [63:0] rsp_module_hash_out,
   output logic [63:0] rsp_content_hash_out,
   output logic [63:0] rsp_contract_hash_out,
   output logic [31:0] rsp_profile_out
);

   localparam logic [1:0] FSM_IDLE = 2'd0;
   localparam logic [1:0] FSM_SCAN = 2'd1;
   localparam logic [1:0] FSM_DONE = 2'd2;

   logic [63:0] gen_ff [SLOTS];
   logic [63:0] mh_ff [SLOTS];
   logic [63:0] ch_ff [SLOTS];
   logic [63:0] kh_ff [SLOTS];
   logic [31:0] prof_ff [SLOTS];
   logic [1:0]  st_ff [SLOTS];
   logic [31:0] lease_ff [SLOTS];

   logic [63:0] next_gen_ff;
   slot_type    act_slot_ff;
   logic        act_valid_ff;
   logic [4:0]  cap_reg_ff;

   logic [1:0]  fsm_ff, fsm_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic        found_ff, found_in;
   slot_type    hit_ff, hit_in;
   logic [4:0]  ncol_ff, ncol_in;

   logic [2:0]  op_ff;
   slot_type    slot_ff;
   logic        hrec_ff, hlease_ff, pok_ff;
   logic [63:0] hgen_ff, mhi_ff, chi_ff, khi_ff;
   logic [31:0] profi_ff;

   logic [CNT_W-1:0] cap;
   slot_type    cur;
   logic        belongs;
   logic        scan_op;
   logic        scan_end;
   logic        match;
   logic        collectable;

   assign cap = (cap_reg_ff > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : cap_reg_ff;
   assign cur = idx_ff[SLOT_W-1:0];
   assign belongs = {1'b0, slot_ff} < cap;
   assign scan_op = (op_ff == OP_PREPARE) || (op_ff == OP_ACQ_GEN) ||
                    (op_ff == OP_COLLECT);
   assign scan_end = (idx_ff >= cap) || found_ff;

   // shared compare unit: one slot examined per cycle
   always_comb begin
      match = 1'b0;
      unique case (op_ff)
         OP_PREPARE: match = st_ff[cur] == S_FREE;
         OP_ACQ_GEN: match = gen_ff[cur] == hgen_ff;
         default:    match = 1'b0;
      endcase
   end
   assign collectable = (!act_valid_ff || cur != act_slot_ff) &&
                        st_ff[cur] == S_RETIRED && lease_ff[cur] == 32'd0;

   assign busy = fsm_ff != FSM_IDLE;
   assign csr_ready = fsm_ff == FSM_IDLE;

   always_comb begin
      fsm_in = fsm_ff;
      idx_in = idx_ff;
      found_in = found_ff;
      hit_in = hit_ff;
      ncol_in = ncol_ff;
      unique case (fsm_ff)
         FSM_IDLE: begin
            if (start) begin
               fsm_in = FSM_SCAN;
               idx_in = '0;
               found_in = 1'b0;
               hit_in = '0;
               ncol_in = '0;
            end
         end
         FSM_SCAN: begin
            if (!scan_op || scan_end) begin
               fsm_in = FSM_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
               if (match) begin
                  found_in = 1'b1;
                  hit_in = cur;
               end
               if (op_ff == OP_COLLECT && collectable) begin
                  ncol_in = ncol_ff + 1'b1;
               end
            end
         end
         FSM_DONE: fsm_in = FSM_IDLE;
         default:  fsm_in = FSM_IDLE;
      endcase
   end

   // finishing step: result and table update from the registered scan outcome
   logic        fin;
   logic [2:0]  r_st;
   slot_type    r_slot;
   logic [63:0] r_gen, r_exp;
   logic [31:0] r_cnt;
   logic        r_lea;
   logic [1:0]  r_rst;
   logic [63:0] r_mh, r_ch, r_kh;
   logic [31:0] r_pf;
   logic        do_prep, do_pub, do_lease, do_rel;
   slot_type    lease_idx;
   logic [31:0] lease_inc;
   slot_type    sl;

   assign fin = fsm_ff == FSM_DONE;
   assign sl = slot_ff;
   assign lease_inc = lease_ff[lease_idx] + 32'd1;

   always_comb begin
      r_st = ST_OK; r_slot = '0; r_gen = '0; r_exp = '0; r_cnt = '0; r_lea = 1'b0;
      r_rst = '0; r_mh = '0; r_ch = '0; r_kh = '0; r_pf = '0;
      do_prep = 1'b0; do_pub = 1'b0; do_lease = 1'b0; do_rel = 1'b0;
      lease_idx = '0;
      unique case (op_ff)
         OP_PREPARE: begin
            if (!pok_ff || chi_ff == 64'd0 || mhi_ff == 64'd0) begin
               r_st = ST_INVALID;
            end else if (!found_ff) begin
               r_st = ST_CAPACITY;
            end else if (next_gen_ff == '1) begin
               r_st = ST_OVERFLOW;
            end else begin
               do_prep = 1'b1;
               r_slot = hit_ff;
               r_gen = next_gen_ff + 64'd1;
            end
         end
         OP_PUBLISH: begin
            r_slot = sl;
            r_lea = hlease_ff;
            if (!hrec_ff || hlease_ff) begin
               r_st = ST_INVALID;
            end else if (!belongs || gen_ff[sl] != hgen_ff || st_ff[sl] != S_PREPARED) begin
               r_st = ST_NOT_PREPARED;
               r_exp = hgen_ff;
               r_gen = belongs ? gen_ff[sl] : 64'd0;
            end else begin
               do_pub = 1'b1;
               r_gen = hgen_ff;
            end
         end
         OP_ACQ_ACTIVE, OP_ACQ_GEN: begin
            if (op_ff == OP_ACQ_ACTIVE) begin
               lease_idx = act_slot_ff;
            end else begin
               lease_idx = hit_ff;
            end
            if (op_ff == OP_ACQ_GEN && hgen_ff == 64'd0) begin
               r_st = ST_INVALID;
               r_exp = hgen_ff;
            end else if ((op_ff == OP_ACQ_ACTIVE ? !act_valid_ff : !found_ff) ||
                         st_ff[lease_idx] == S_FREE) begin
               r_st = ST_STALE;
               r_gen = (op_ff == OP_ACQ_ACTIVE ? act_valid_ff : found_ff) ?
                       gen_ff[lease_idx] : 64'd0;
            end else begin
               do_lease = 1'b1;
               r_slot = lease_idx;
               r_lea = 1'b1;
               r_gen = gen_ff[lease_idx];
               r_cnt = lease_inc;
            end
         end
         OP_RESOLVE: begin
            r_slot = sl;
            r_lea = hlease_ff;
            if (!hrec_ff || !hlease_ff) begin
               r_st = ST_INVALID;
            end else if (!belongs || gen_ff[sl] != hgen_ff || st_ff[sl] == S_FREE) begin
               r_st = ST_STALE;
               r_exp = hgen_ff;
               r_gen = belongs ? gen_ff[sl] : 64'd0;
            end else begin
               r_rst = st_ff[sl];
               r_mh = mh_ff[sl];
               r_ch = ch_ff[sl];
               r_kh = kh_ff[sl];
               r_pf = prof_ff[sl];
               r_gen = hgen_ff;
               r_cnt = lease_ff[sl];
            end
         end
         OP_RELEASE: begin
            r_slot = sl;
            r_lea = hlease_ff;
            if (!hrec_ff || !hlease_ff) begin
               r_st = ST_INVALID;
            end else if (!belongs || gen_ff[sl] != hgen_ff) begin
               r_st = ST_STALE;
               r_exp = hgen_ff;
            end else if (lease_ff[sl] == 32'd0) begin
               r_st = ST_BAD_STATE;
               r_exp = hgen_ff;
               r_gen = hgen_ff;
            end else begin
               do_rel = 1'b1;
               r_lea = 1'b0;
               r_gen = hgen_ff;
               r_cnt = lease_ff[sl] - 32'd1;
            end
         end
         OP_COLLECT: r_cnt = {27'd0, ncol_ff};
         default:    r_st = ST_INVALID;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= FSM_IDLE;
         idx_ff <= '0;
         found_ff <= 1'b0;
         hit_ff <= '0;
         ncol_ff <= '0;
         next_gen_ff <= '0;
         act_slot_ff <= '0;
         act_valid_ff <= 1'b0;
         cap_reg_ff <= 5'd16;
         rsp_valid <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            gen_ff[i] <= '0; mh_ff[i] <= '0; ch_ff[i] <= '0; kh_ff[i] <= '0;
            prof_ff[i] <= '0; st_ff[i] <= S_FREE; lease_ff[i] <= '0;
         end
      end else begin
         fsm_ff <= fsm_in;
         idx_ff <= idx_in;
         found_ff <= found_in;
         hit_ff <= hit_in;
         ncol_ff <= ncol_in;
         rsp_valid <= fin;
         if (csr_valid && csr_ready) begin
            cap_reg_ff <= csr_data;
         end
         // clear each retired, unleased slot other than the active one as the scan passes it
         if (fsm_ff == FSM_SCAN && op_ff == OP_COLLECT && !scan_end && collectable) begin
            gen_ff[cur] <= '0; mh_ff[cur] <= '0; ch_ff[cur] <= '0; kh_ff[cur] <= '0;
            prof_ff[cur] <= '0; st_ff[cur] <= S_FREE; lease_ff[cur] <= '0;
         end
         if (fin && do_prep) begin
            next_gen_ff <= r_gen;
            gen_ff[hit_ff] <= r_gen;
            mh_ff[hit_ff] <= mhi_ff;
            ch_ff[hit_ff] <= chi_ff;
            kh_ff[hit_ff] <= khi_ff;
            prof_ff[hit_ff] <= profi_ff;
            lease_ff[hit_ff] <= '0;
            st_ff[hit_ff] <= S_PREPARED;
         end
         if (fin && do_pub) begin
            if (act_valid_ff && act_slot_ff != sl && st_ff[act_slot_ff] == S_ACTIVE) begin
               st_ff[act_slot_ff] <= S_RETIRED;
            end
            st_ff[sl] <= S_ACTIVE;
            act_slot_ff <= sl;
            act_valid_ff <= 1'b1;
         end
         if (fin && do_lease) begin
            lease_ff[lease_idx] <= lease_inc;
         end
         if (fin && do_rel) begin
            lease_ff[sl] <= r_cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         op_ff <= req_op;
         slot_ff <= req_slot;
         hrec_ff <= req_handle_has_record;
         hgen_ff <= req_handle_generation;
         hlease_ff <= req_handle_leased;
         pok_ff <= req_patch_ok;
         mhi_ff <= req_module_hash;
         chi_ff <= req_content_hash;
         khi_ff <= req_contract_hash;
         profi_ff <= req_target_profile;
      end
      if (fin) begin
         rsp_status <= r_st;
         rsp_slot_out <= r_slot;
         rsp_result_generation <= r_gen;
         rsp_expected_generation <= r_exp;
         rsp_count_out <= r_cnt;
         rsp_leased_out <= r_lea;
         rsp_record_state <= r_rst;
         rsp_module_hash_out <= r_mh;
         rsp_content_hash_out <= r_ch;
         rsp_contract_hash_out <= r_kh;
         rsp_profile_out <= r_pf;
      end
   end

endmodule

FILE: hw/rtl/vslt_checker.sv
// Port-level checker for the versioned slot lease table, with its bind.
module vslt_props
   import vslt_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       csr_ready,
   input logic       rsp_valid,
   input logic [2:0] rsp_status
);

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("request beat did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result beat while still busy");

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result beat held two cycles");

   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !busy) else $error("csr ready while busy");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 3'd7) else $error("undefined status code");

endmodule

bind versioned_slot_lease_table vslt_props u_vslt_props (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .csr_ready(csr_ready), .rsp_valid(rsp_valid), .rsp_status(rsp_status)
);
